/* hdl/lfjt_pkg.sv */
// shared constants and codes for the line-follow junction and turn mode machine
package lfjt_pkg;

    localparam int TIME_BITS = 32;

    localparam int ADC_W   = 8;
    localparam int SUM_W   = 9;
    localparam int DRIVE_W = 9;
    localparam int MODE_W  = 4;
    localparam int LEVEL_W = 9;
    localparam int DUR_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // mode codes
    localparam logic [MODE_W-1:0] M_FOLLOW  = 4'd0;
    localparam logic [MODE_W-1:0] M_SCAN    = 4'd1;
    localparam logic [MODE_W-1:0] M_LEFT    = 4'd2;
    localparam logic [MODE_W-1:0] M_RIGHT   = 4'd3;
    localparam logic [MODE_W-1:0] M_UTURN   = 4'd4;
    localparam logic [MODE_W-1:0] M_SETUP   = 4'd5;
    localparam logic [MODE_W-1:0] M_FAST    = 4'd6;
    localparam logic [MODE_W-1:0] M_CAPTURE = 4'd7;
    localparam logic [MODE_W-1:0] M_SETTLE  = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_LINE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUNC_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTH_BRANCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUND_LINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JUNC_TIME    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TIME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TIME = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TIME    = 3'd7;

    localparam logic [LEVEL_W-1:0] RST_OFF_LINE     = 9'd125;
    localparam logic [LEVEL_W-1:0] RST_JUNC_START   = 9'd285;
    localparam logic [LEVEL_W-1:0] RST_BOTH_BRANCH  = 9'd360;
    localparam logic [LEVEL_W-1:0] RST_FOUND_LINE   = 9'd150;
    localparam logic [DUR_W-1:0]   RST_JUNC_TIME    = 16'd150;
    localparam logic [DUR_W-1:0]   RST_SETUP_TIME   = 16'd500;
    localparam logic [DUR_W-1:0]   RST_QUARTER_TIME = 16'd500;
    localparam logic [DUR_W-1:0]   RST_HALF_TIME    = 16'd1000;

    localparam logic [ADC_W-1:0] SPEED_DRIVE = 8'd138;
    localparam logic [ADC_W-1:0] SPEED_SLOW  = 8'd80;
    localparam logic signed [DRIVE_W-1:0] TURN_FAST_POS = 9'sd128;
    localparam logic signed [DRIVE_W-1:0] TURN_FAST_NEG = -9'sd128;
    localparam logic signed [DRIVE_W-1:0] TURN_SLOW_POS = 9'sd70;
    localparam logic signed [DRIVE_W-1:0] TURN_SLOW_NEG = -9'sd70;
    localparam logic [DUR_W-1:0] SETTLE_TIME = 16'd125;

endpackage

/* hdl/lfjt_in_if.sv */
// sensor item channel: one averaged sensor pair and its timestamp
interface lfjt_in_if
    import lfjt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [ADC_W-1:0]      adc_left;
    logic [ADC_W-1:0]      adc_right;
    logic [TIME_BITS-1:0]  time_ms;

    modport source (output valid, output adc_left, output adc_right, output time_ms,
                    input ready);
    modport sink (input valid, input adc_left, input adc_right, input time_ms,
                  output ready);
    modport mon (input valid, input ready, input adc_left, input adc_right,
                 input time_ms);
endinterface

/* hdl/lfjt_out_if.sv */
// result item channel: motor drives, junction report flags and mode
interface lfjt_out_if
    import lfjt_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [DRIVE_W-1:0]  left_drive;
    logic signed [DRIVE_W-1:0]  right_drive;
    logic                       found_left;
    logic                       found_right;
    logic                       found_forward;
    logic                       dead_end;
    logic [MODE_W-1:0]          mode;

    modport source (output valid, output left_drive, output right_drive,
                    output found_left, output found_right, output found_forward,
                    output dead_end, output mode, input ready);
    modport sink (input valid, input left_drive, input right_drive,
                  input found_left, input found_right, input found_forward,
                  input dead_end, input mode, output ready);
    modport mon (input valid, input ready, input left_drive, input right_drive,
                 input found_left, input found_right, input found_forward,
                 input dead_end, input mode);
endinterface

/* hdl/line_follow_junction_turn_fsm.sv */
// line-follow mode machine: junction scan, turn sequencing and steering drive
//
//  channel   | dir | handshake       | payload
//  i_item    | in  | valid / ready   | adc_left, adc_right, time_ms
//  o_result  | out | valid / ready   | left_drive, right_drive, found_*, dead_end, mode
//  i_cfg_*   | in  | write enable    | 3-bit register index, 16-bit data
//
// one item per cycle sustained while the result is not stalled; an accepted item
// passes the input register, then mode logic into the result register
// the mode state updates in the same cycle the result register loads
// reset is synchronous, active low; config returns to its defaults
// a stalled result holds; one more item may wait in the input register meanwhile
module line_follow_junction_turn_fsm
    import lfjt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lfjt_in_if.sink                i_item,
    lfjt_out_if.source             o_result,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration
    logic [LEVEL_W-1:0] r_off_line, r_junc_start, r_both_branch, r_found_line;
    logic [DUR_W-1:0]   r_junc_time, r_setup_time, r_quarter_time, r_half_time;

    // input stage
    logic                 r_in_valid;
    logic [ADC_W-1:0]     r_adc_l, r_adc_r;
    logic [TIME_BITS-1:0] r_time;

    // mode state
    logic [MODE_W-1:0]         r_mode, n_mode;
    logic [TIME_BITS-1:0]      r_mode_start, n_mode_start;
    logic [SUM_W-1:0]          r_peak_sum, n_peak_sum;
    logic [ADC_W-1:0]          r_left_pk, n_left_pk, r_right_pk, n_right_pk;
    logic                      r_cw, n_cw;
    logic [DUR_W-1:0]          r_turn_dur, n_turn_dur;
    logic [ADC_W-1:0]          r_base, n_base;
    logic signed [DRIVE_W-1:0] r_left_held, n_left_held, r_right_held, n_right_held;

    // result stage
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_left, r_out_right;
    logic                      r_out_fl, r_out_fr, r_out_ff, r_out_dead;
    logic [MODE_W-1:0]         r_out_mode;

    logic                 c_advance, c_fire;
    logic [SUM_W-1:0]     c_sum;
    logic signed [9:0]    c_d, c_diff, c_lsum, c_rsum;
    logic [TIME_BITS-1:0] c_elapsed;
    logic                 c_off, c_steer;
    logic                 n_fl, n_fr, n_ff, n_dead;

    assign c_advance    = !r_out_valid || o_result.ready;
    assign c_fire       = r_in_valid && c_advance;
    assign i_item.ready = !r_in_valid || c_advance;

    assign c_sum = {1'b0, r_adc_l} + {1'b0, r_adc_r};
    assign c_d   = $signed({2'b00, r_adc_l}) - $signed({2'b00, r_adc_r});
    // quarter difference, truncated toward zero
    assign c_diff = (c_d + (c_d[9] ? 10'sd3 : 10'sd0)) >>> 2;
    assign c_elapsed = r_time - r_mode_start;
    assign c_off = c_sum < r_off_line;

    always_comb begin
        n_mode       = r_mode;
        n_mode_start = r_mode_start;
        n_peak_sum   = r_peak_sum;
        n_left_pk    = r_left_pk;
        n_right_pk   = r_right_pk;
        n_cw         = r_cw;
        n_turn_dur   = r_turn_dur;
        n_base       = r_base;
        n_left_held  = r_left_held;
        n_right_held = r_right_held;
        n_fl         = 1'b0;
        n_fr         = 1'b0;
        n_ff         = 1'b0;
        n_dead       = 1'b0;
        c_steer      = 1'b1;
        c_lsum       = '0;
        c_rsum       = '0;

        unique case (r_mode)
            M_FOLLOW: begin
                n_dead = c_off;
                if (c_sum > r_junc_start) begin
                    n_peak_sum   = '0;
                    n_left_pk    = '0;
                    n_right_pk   = '0;
                    n_mode       = M_SCAN;
                    n_mode_start = r_time;
                end
                n_base = SPEED_DRIVE;
            end
            M_SCAN: begin
                if (c_sum > r_peak_sum) begin
                    n_peak_sum = c_sum;
                    n_left_pk  = r_adc_l;
                    n_right_pk = r_adc_r;
                end
                if (c_off || (c_elapsed > TIME_BITS'(r_junc_time))) begin
                    if (n_peak_sum > r_both_branch) begin
                        n_fl = 1'b1;
                        n_fr = 1'b1;
                    end else if (n_left_pk > n_right_pk) begin
                        n_fl = 1'b1;
                    end else begin
                        n_fr = 1'b1;
                    end
                    n_ff = !c_off;
                end
            end
            M_RIGHT: begin
                n_cw         = 1'b1;
                n_turn_dur   = r_quarter_time;
                n_mode       = M_SETUP;
                n_mode_start = r_time;
            end
            M_LEFT: begin
                n_cw         = 1'b0;
                n_turn_dur   = r_quarter_time;
                n_mode       = M_SETUP;
                n_mode_start = r_time;
            end
            M_UTURN: begin
                n_cw         = 1'b1;
                n_turn_dur   = r_half_time;
                n_mode       = M_SETUP;
                n_mode_start = r_time;
            end
            M_SETUP: begin
                if (c_elapsed > TIME_BITS'(r_setup_time)) begin
                    n_left_held  = r_cw ? TURN_FAST_POS : TURN_FAST_NEG;
                    n_right_held = r_cw ? TURN_FAST_NEG : TURN_FAST_POS;
                    n_mode       = M_FAST;
                    n_mode_start = r_time;
                    c_steer      = 1'b0;
                end
            end
            M_FAST: begin
                if (c_elapsed > TIME_BITS'(r_turn_dur)) begin
                    n_left_held  = r_cw ? TURN_SLOW_POS : TURN_SLOW_NEG;
                    n_right_held = r_cw ? TURN_SLOW_NEG : TURN_SLOW_POS;
                    n_mode       = M_CAPTURE;
                    n_mode_start = r_time;
                end
                c_steer = 1'b0;
            end
            M_CAPTURE: begin
                if (c_sum > r_found_line) begin
                    n_mode       = M_SETTLE;
                    n_mode_start = r_time;
                    n_base       = SPEED_SLOW;
                end else begin
                    c_steer = 1'b0;
                end
            end
            M_SETTLE: begin
                if (c_elapsed > TIME_BITS'(SETTLE_TIME)) begin
                    n_mode       = M_FOLLOW;
                    n_mode_start = r_time;
                    n_base       = SPEED_DRIVE;
                end
            end
            default: begin
                c_steer = 1'b0;
            end
        endcase

        if (c_steer) begin
            c_lsum       = $signed({2'b00, n_base}) - c_diff;
            c_rsum       = $signed({2'b00, n_base}) + c_diff;
            n_left_held  = c_lsum[DRIVE_W-1:0];
            n_right_held = c_rsum[DRIVE_W-1:0];
            if (n_fl || n_fr || n_ff || n_dead) begin
                n_left_held  = '0;
                n_right_held = '0;
                n_mode_start = r_time;
                // dead end first, then right, then left
                priority if (n_dead) begin
                    n_mode = M_UTURN;
                end else if (n_fr) begin
                    n_mode = M_RIGHT;
                end else if (n_fl) begin
                    n_mode = M_LEFT;
                end else begin
                    n_mode = M_FOLLOW;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_line     <= RST_OFF_LINE;
            r_junc_start   <= RST_JUNC_START;
            r_both_branch  <= RST_BOTH_BRANCH;
            r_found_line   <= RST_FOUND_LINE;
            r_junc_time    <= RST_JUNC_TIME;
            r_setup_time   <= RST_SETUP_TIME;
            r_quarter_time <= RST_QUARTER_TIME;
            r_half_time    <= RST_HALF_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFF_LINE:     r_off_line     <= i_cfg_data[LEVEL_W-1:0];
                CFG_JUNC_START:   r_junc_start   <= i_cfg_data[LEVEL_W-1:0];
                CFG_BOTH_BRANCH:  r_both_branch  <= i_cfg_data[LEVEL_W-1:0];
                CFG_FOUND_LINE:   r_found_line   <= i_cfg_data[LEVEL_W-1:0];
                CFG_JUNC_TIME:    r_junc_time    <= i_cfg_data[DUR_W-1:0];
                CFG_SETUP_TIME:   r_setup_time   <= i_cfg_data[DUR_W-1:0];
                CFG_QUARTER_TIME: r_quarter_time <= i_cfg_data[DUR_W-1:0];
                CFG_HALF_TIME:    r_half_time    <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_adc_l <= i_item.adc_left;
            r_adc_r <= i_item.adc_right;
            r_time  <= i_item.time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_FOLLOW;
            r_mode_start <= '0;
            r_peak_sum   <= '0;
            r_left_pk    <= '0;
            r_right_pk   <= '0;
            r_cw         <= 1'b0;
            r_turn_dur   <= '0;
            r_base       <= '0;
            r_left_held  <= '0;
            r_right_held <= '0;
        end else if (c_fire) begin
            r_mode       <= n_mode;
            r_mode_start <= n_mode_start;
            r_peak_sum   <= n_peak_sum;
            r_left_pk    <= n_left_pk;
            r_right_pk   <= n_right_pk;
            r_cw         <= n_cw;
            r_turn_dur   <= n_turn_dur;
            r_base       <= n_base;
            r_left_held  <= n_left_held;
            r_right_held <= n_right_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            r_out_left  <= n_left_held;
            r_out_right <= n_right_held;
            r_out_fl    <= n_fl;
            r_out_fr    <= n_fr;
            r_out_ff    <= n_ff;
            r_out_dead  <= n_dead;
            r_out_mode  <= n_mode;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.left_drive    = r_out_left;
    assign o_result.right_drive   = r_out_right;
    assign o_result.found_left    = r_out_fl;
    assign o_result.found_right   = r_out_fr;
    assign o_result.found_forward = r_out_ff;
    assign o_result.dead_end      = r_out_dead;
    assign o_result.mode          = r_out_mode;

endmodule

/* hdl/lfjt_checker.sv */
// port-level checks for the line-follow mode machine, bound to the top level
module lfjt_checker
    import lfjt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_ready,
    input  logic signed [DRIVE_W-1:0] i_left_drive,
    input  logic signed [DRIVE_W-1:0] i_right_drive,
    input  logic                      i_found_left,
    input  logic                      i_found_right,
    input  logic                      i_found_forward,
    input  logic                      i_dead_end,
    input  logic [MODE_W-1:0]         i_mode
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=>
            i_valid && $stable(i_left_drive) &&
            $stable(i_right_drive) && $stable(i_mode))
        else $error("result changed while stalled");

    // any report stops both motors
    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_found_left || i_found_right ||
                    i_found_forward || i_dead_end) |->
            i_left_drive == '0 && i_right_drive == '0)
        else $error("report without zeroed drives");

    // dead end always leads to a u-turn
    a_dead_uturn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_dead_end |-> i_mode == M_UTURN)
        else $error("dead end without u-turn");

    // a forward report comes only with a branch report
    a_fwd_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_found_forward |->
            (i_found_left || i_found_right) && !i_dead_end)
        else $error("forward report without a branch");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

endmodule

bind line_follow_junction_turn_fsm lfjt_checker u_lfjt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_result.valid),
    .i_ready         (o_result.ready),
    .i_left_drive    (o_result.left_drive),
    .i_right_drive   (o_result.right_drive),
    .i_found_left    (o_result.found_left),
    .i_found_right   (o_result.found_right),
    .i_found_forward (o_result.found_forward),
    .i_dead_end      (o_result.dead_end),
    .i_mode          (o_result.mode)
);

/* verif/tb.sv */
// self-checking testbench for the line-follow junction and turn mode machine
module tb
    import lfjt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic [DRIVE_W-1:0] left_drive;
        logic [DRIVE_W-1:0] right_drive;
        logic               found_left;
        logic               found_right;
        logic               found_forward;
        logic               dead_end;
        logic [MODE_W-1:0]  mode;
    } t_drive_report;

    typedef logic [7:0][CFG_DATA_W-1:0] t_reg_image;

    typedef enum int {BAND_LOW, BAND_MID, BAND_HIGH, BAND_ANY} t_sensor_band;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    lfjt_in_if  sensor_if ();
    lfjt_out_if drive_if ();

    line_follow_junction_turn_fsm u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (sensor_if),
        .o_result   (drive_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted machine state and register copy
    logic [MODE_W-1:0]    nav_mode   = M_FOLLOW;
    logic [TIME_BITS-1:0] nav_start  = '0;
    int                   peak_sum   = 0;
    int                   peak_left  = 0;
    int                   peak_right = 0;
    bit                   turn_cw    = 1'b0;
    logic [DUR_W-1:0]     turn_len   = '0;
    int                   speed_base = 0;
    int                   held_left  = 0;
    int                   held_right = 0;
    logic [CFG_DATA_W-1:0] cfg_val [8];

    t_drive_report expected_q [$];
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    logic [TIME_BITS-1:0] clock_ms = '0;

    function automatic void change_mode(logic [MODE_W-1:0] m, logic [TIME_BITS-1:0] now);
        nav_mode  = m;
        nav_start = now;
    endfunction

    function automatic t_drive_report predict_report(logic [ADC_W-1:0] al,
                                                     logic [ADC_W-1:0] ar,
                                                     logic [TIME_BITS-1:0] now);
        t_drive_report res;
        int l, r, diff, sum, dir;
        logic [TIME_BITS-1:0] elapsed;
        bit steer, fl, fr, ff, fd;
        l = int'(al);
        r = int'(ar);
        diff = (l - r) / 4;
        sum = l + r;
        elapsed = now - nav_start;
        steer = 1'b1;
        fl = 1'b0;
        fr = 1'b0;
        ff = 1'b0;
        fd = 1'b0;
        dir = turn_cw ? 1 : -1;
        case (nav_mode)
            M_FOLLOW: begin
                if (sum < int'(cfg_val[CFG_OFF_LINE])) fd = 1'b1;
                if (sum > int'(cfg_val[CFG_JUNC_START])) begin
                    peak_sum   = 0;
                    peak_left  = 0;
                    peak_right = 0;
                    change_mode(M_SCAN, now);
                end
                speed_base = int'(SPEED_DRIVE);
            end
            M_SCAN: begin
                if (sum > peak_sum) begin
                    peak_sum   = sum;
                    peak_left  = l;
                    peak_right = r;
                end
                if (sum < int'(cfg_val[CFG_OFF_LINE]) ||
                    elapsed > TIME_BITS'(cfg_val[CFG_JUNC_TIME])) begin
                    if (peak_sum > int'(cfg_val[CFG_BOTH_BRANCH])) begin
                        fl = 1'b1;
                        fr = 1'b1;
                    end else if (peak_left > peak_right) begin
                        fl = 1'b1;
                    end else begin
                        fr = 1'b1;
                    end
                    if (!(sum < int'(cfg_val[CFG_OFF_LINE]))) ff = 1'b1;
                end
            end
            M_RIGHT: begin
                turn_cw  = 1'b1;
                turn_len = cfg_val[CFG_QUARTER_TIME];
                change_mode(M_SETUP, now);
            end
            M_LEFT: begin
                turn_cw  = 1'b0;
                turn_len = cfg_val[CFG_QUARTER_TIME];
                change_mode(M_SETUP, now);
            end
            M_UTURN: begin
                turn_cw  = 1'b1;
                turn_len = cfg_val[CFG_HALF_TIME];
                change_mode(M_SETUP, now);
            end
            M_SETUP: begin
                if (elapsed > TIME_BITS'(cfg_val[CFG_SETUP_TIME])) begin
                    held_left  = dir * int'(TURN_FAST_POS);
                    held_right = -dir * int'(TURN_FAST_POS);
                    change_mode(M_FAST, now);
                    steer = 1'b0;
                end
            end
            M_FAST: begin
                if (elapsed > TIME_BITS'(turn_len)) begin
                    held_left  = dir * int'(TURN_SLOW_POS);
                    held_right = -dir * int'(TURN_SLOW_POS);
                    change_mode(M_CAPTURE, now);
                end
                steer = 1'b0;
            end
            M_CAPTURE: begin
                if (!(sum > int'(cfg_val[CFG_FOUND_LINE]))) begin
                    steer = 1'b0;
                end else begin
                    change_mode(M_SETTLE, now);
                    speed_base = int'(SPEED_SLOW);
                end
            end
            M_SETTLE: begin
                if (elapsed > TIME_BITS'(SETTLE_TIME)) begin
                    change_mode(M_FOLLOW, now);
                    speed_base = int'(SPEED_DRIVE);
                end
            end
            default: begin
                steer = 1'b0;
            end
        endcase
        if (steer) begin
            held_left  = speed_base - diff;
            held_right = speed_base + diff;
            if (fl || fr || ff || fd) begin
                held_left  = 0;
                held_right = 0;
                // report priority: dead end, right, left, straight on
                if (fd)      change_mode(M_UTURN, now);
                else if (fr) change_mode(M_RIGHT, now);
                else if (fl) change_mode(M_LEFT, now);
                else         change_mode(M_FOLLOW, now);
            end
        end
        res.left_drive    = held_left[DRIVE_W-1:0];
        res.right_drive   = held_right[DRIVE_W-1:0];
        res.found_left    = fl;
        res.found_right   = fr;
        res.found_forward = ff;
        res.dead_end      = fd;
        res.mode          = nav_mode;
        return res;
    endfunction

    function automatic t_reg_image make_image(int off, int junc, int both, int found,
                                              int jt, int st, int qt, int ht);
        t_reg_image img;
        img[CFG_OFF_LINE]     = CFG_DATA_W'(off);
        img[CFG_JUNC_START]   = CFG_DATA_W'(junc);
        img[CFG_BOTH_BRANCH]  = CFG_DATA_W'(both);
        img[CFG_FOUND_LINE]   = CFG_DATA_W'(found);
        img[CFG_JUNC_TIME]    = CFG_DATA_W'(jt);
        img[CFG_SETUP_TIME]   = CFG_DATA_W'(st);
        img[CFG_QUARTER_TIME] = CFG_DATA_W'(qt);
        img[CFG_HALF_TIME]    = CFG_DATA_W'(ht);
        return img;
    endfunction

    function automatic t_reg_image default_image();
        return make_image(int'(RST_OFF_LINE), int'(RST_JUNC_START),
                          int'(RST_BOTH_BRANCH), int'(RST_FOUND_LINE),
                          int'(RST_JUNC_TIME), int'(RST_SETUP_TIME),
                          int'(RST_QUARTER_TIME), int'(RST_HALF_TIME));
    endfunction

    // plausible thresholds, with junk above bit 8 of the level registers
    function automatic t_reg_image random_image();
        return make_image($urandom_range(200, 60)  | ($urandom_range(127) << LEVEL_W),
                          $urandom_range(400, 200) | ($urandom_range(127) << LEVEL_W),
                          $urandom_range(480, 250) | ($urandom_range(127) << LEVEL_W),
                          $urandom_range(300, 80)  | ($urandom_range(127) << LEVEL_W),
                          $urandom_range(300), $urandom_range(600),
                          $urandom_range(600), $urandom_range(1200));
    endfunction

    // sensor band weighted by the mode the next item will meet
    function automatic logic [2*ADC_W-1:0] pick_sensors(logic [MODE_W-1:0] m);
        int roll, p_low, p_high, p_any;
        t_sensor_band band;
        logic [ADC_W-1:0] l, r;
        roll = $urandom_range(99);
        case (m)
            M_FOLLOW:  begin p_low = 10; p_high = 15; p_any = 15; end
            M_SCAN:    begin p_low = 20; p_high = 45; p_any = 15; end
            M_CAPTURE: begin p_low = 45; p_high = 0;  p_any = 25; end
            default:   begin p_low = 10; p_high = 10; p_any = 40; end
        endcase
        if (roll < p_low)                       band = BAND_LOW;
        else if (roll < p_low + p_high)         band = BAND_HIGH;
        else if (roll < p_low + p_high + p_any) band = BAND_ANY;
        else                                    band = BAND_MID;
        case (band)
            BAND_LOW: begin
                l = ADC_W'($urandom_range(62));
                r = ADC_W'($urandom_range(62));
            end
            BAND_MID: begin
                l = ADC_W'($urandom_range(140, 70));
                r = ADC_W'($urandom_range(140, 70));
            end
            BAND_HIGH: begin
                l = ADC_W'($urandom_range(255, 143));
                r = ADC_W'($urandom_range(255, 143));
            end
            default: begin
                l = ADC_W'($urandom_range(255));
                r = ADC_W'($urandom_range(255));
            end
        endcase
        return {l, r};
    endfunction

    function automatic logic [TIME_BITS-1:0] next_ms(int step_max);
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)       clock_ms = $urandom;
        else if (roll < 15) clock_ms = clock_ms + $urandom_range(3);
        else                clock_ms = clock_ms + $urandom_range(step_max);
        return clock_ms;
    endfunction

    task automatic send_sample(logic [ADC_W-1:0] al, logic [ADC_W-1:0] ar,
                               logic [TIME_BITS-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            sensor_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        sensor_if.valid     <= 1'b1;
        sensor_if.adc_left  <= al;
        sensor_if.adc_right <= ar;
        sensor_if.time_ms   <= t;
        do @(posedge i_clk); while (!sensor_if.ready);
        expected_q.push_back(predict_report(al, ar, t));
    endtask

    task automatic wait_results_drained();
        sensor_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(t_reg_image img);
        for (int i = 0; i < 8; i++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= img[i];
            cfg_val[i] = (i <= int'(CFG_FOUND_LINE))
                       ? (img[i] & CFG_DATA_W'((1 << LEVEL_W) - 1))
                       : img[i];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int n_items, int step_max);
        logic [2*ADC_W-1:0] pair;
        logic [TIME_BITS-1:0] t;
        repeat (n_items) begin
            pair = pick_sensors(nav_mode);
            t = next_ms(step_max);
            send_sample(pair[2*ADC_W-1:ADC_W], pair[ADC_W-1:0], t);
        end
    endtask

    // steering extremes, a two-branch junction and a full right turn cycle
    task automatic test_right_turn_cycle();
        logic [TIME_BITS-1:0] tm;
        tm = 32'd1000;
        send_sample(8'd100, 8'd100, tm);
        send_sample(8'd255, 8'd0,   tm + 1);
        send_sample(8'd0,   8'd255, tm + 2);
        send_sample(8'd130, 8'd127, tm + 3);
        send_sample(8'd127, 8'd134, tm + 4);
        tm = tm + 10;
        send_sample(8'd200, 8'd200, tm);
        send_sample(8'd255, 8'd255, tm + 5);
        // scan closes only once elapsed passes the limit
        send_sample(8'd150, 8'd150, tm + 32'(RST_JUNC_TIME));
        send_sample(8'd150, 8'd150, tm + 32'(RST_JUNC_TIME) + 1);
        tm = tm + 32'(RST_JUNC_TIME) + 1;
        send_sample(8'd128, 8'd128, tm + 1);
        tm = tm + 1;
        send_sample(8'd128, 8'd128, tm + 32'(RST_SETUP_TIME));
        send_sample(8'd128, 8'd128, tm + 32'(RST_SETUP_TIME) + 1);
        tm = tm + 32'(RST_SETUP_TIME) + 1;
        send_sample(8'd20, 8'd20, tm + 32'(RST_QUARTER_TIME));
        send_sample(8'd20, 8'd20, tm + 32'(RST_QUARTER_TIME) + 1);
        tm = tm + 32'(RST_QUARTER_TIME) + 1;
        send_sample(8'd20,  8'd20,  tm + 2);
        send_sample(8'd100, 8'd100, tm + 3);
        tm = tm + 3;
        send_sample(8'd100, 8'd100, tm + 32'(SETTLE_TIME));
        send_sample(8'd100, 8'd100, tm + 32'(SETTLE_TIME) + 1);
        clock_ms = tm + 32'(SETTLE_TIME) + 1;
    endtask

    // lost line and junction start at once, U-turn across the timer wrap, left-only scan
    task automatic test_dead_end_and_left_scan();
        logic [TIME_BITS-1:0] tm;
        tm = clock_ms + 200;
        wait_results_drained();
        program_regs(make_image(300, 100, int'(RST_BOTH_BRANCH), int'(RST_FOUND_LINE),
                                int'(RST_JUNC_TIME), int'(RST_SETUP_TIME),
                                int'(RST_QUARTER_TIME), int'(RST_HALF_TIME)));
        send_sample(8'd100, 8'd100, tm);
        wait_results_drained();
        program_regs(default_image());
        send_sample(8'd128, 8'd128, tm + 1);
        tm = 32'hFFFF_FE00;
        send_sample(8'd128, 8'd128, tm);
        send_sample(8'd128, 8'd128, tm + 32'(RST_HALF_TIME) + 1);
        tm = tm + 32'(RST_HALF_TIME) + 1;
        send_sample(8'd90, 8'd90, tm + 1);
        tm = tm + 1;
        send_sample(8'd100, 8'd100, tm + 32'(SETTLE_TIME) + 1);
        tm = tm + 32'(SETTLE_TIME) + 1;
        // peak lands exactly on the both-branch level: one branch only
        send_sample(8'd200, 8'd150, tm + 1);
        send_sample(8'd220, 8'd140, tm + 2);
        send_sample(8'd60,  8'd10,  tm + 3);
        clock_ms = tm + 3;
    endtask

    task automatic test_random_default_config();
        run_random(350, 60);
    endtask

    task automatic test_random_config_sweep();
        wait_results_drained();
        program_regs(random_image());
        run_random(300, 60);

        send_idle_pct = 73;
        recv_idle_pct = 24;
        wait_results_drained();
        program_regs(make_image(0, 0, 0, 0, 0, 0, 0, 0));
        run_random(250, 30);

        // all ones, level registers masked down to their width
        wait_results_drained();
        program_regs(make_image(65535, 65535, 65535, 65535,
                                65535, 65535, 65535, 65535));
        run_random(150, 40000);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_results_drained();
        program_regs(random_image());
        run_random(300, 60);

        wait_results_drained();
        program_regs(default_image());
        run_random(300, 60);
    endtask

    always @(posedge i_clk) begin : check_results
        t_drive_report want;
        if (i_rst_n && drive_if.valid === 1'b1 && drive_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("result item with no expectation waiting");
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (drive_if.left_drive !== want.left_drive) begin
                    $error("left_drive: expected %0d, got %0d",
                           $signed(want.left_drive), $signed(drive_if.left_drive));
                    fail_count++;
                end
                if (drive_if.right_drive !== want.right_drive) begin
                    $error("right_drive: expected %0d, got %0d",
                           $signed(want.right_drive), $signed(drive_if.right_drive));
                    fail_count++;
                end
                if (drive_if.found_left !== want.found_left) begin
                    $error("found_left: expected %0d, got %0d",
                           want.found_left, drive_if.found_left);
                    fail_count++;
                end
                if (drive_if.found_right !== want.found_right) begin
                    $error("found_right: expected %0d, got %0d",
                           want.found_right, drive_if.found_right);
                    fail_count++;
                end
                if (drive_if.found_forward !== want.found_forward) begin
                    $error("found_forward: expected %0d, got %0d",
                           want.found_forward, drive_if.found_forward);
                    fail_count++;
                end
                if (drive_if.dead_end !== want.dead_end) begin
                    $error("dead_end: expected %0d, got %0d",
                           want.dead_end, drive_if.dead_end);
                    fail_count++;
                end
                if (drive_if.mode !== want.mode) begin
                    $error("mode: expected %0d, got %0d", want.mode, drive_if.mode);
                    fail_count++;
                end
            end
        end
        drive_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (sensor_if.valid && sensor_if.ready)
                     || (drive_if.valid === 1'b1 && drive_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sensor_if.valid     = 1'b0;
        sensor_if.adc_left  = '0;
        sensor_if.adc_right = '0;
        sensor_if.time_ms   = '0;
        drive_if.ready      = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_OFF_LINE;
        cfg_data = '0;
        cfg_val[CFG_OFF_LINE]     = CFG_DATA_W'(RST_OFF_LINE);
        cfg_val[CFG_JUNC_START]   = CFG_DATA_W'(RST_JUNC_START);
        cfg_val[CFG_BOTH_BRANCH]  = CFG_DATA_W'(RST_BOTH_BRANCH);
        cfg_val[CFG_FOUND_LINE]   = CFG_DATA_W'(RST_FOUND_LINE);
        cfg_val[CFG_JUNC_TIME]    = RST_JUNC_TIME;
        cfg_val[CFG_SETUP_TIME]   = RST_SETUP_TIME;
        cfg_val[CFG_QUARTER_TIME] = RST_QUARTER_TIME;
        cfg_val[CFG_HALF_TIME]    = RST_HALF_TIME;
        send_idle_pct = 24;
        recv_idle_pct = 73;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_right_turn_cycle();
        test_dead_end_and_left_scan();
        test_random_default_config();
        test_random_config_sweep();

        wait_results_drained();
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/lfjt_pkg.sv
hdl/lfjt_in_if.sv
hdl/lfjt_out_if.sv
hdl/line_follow_junction_turn_fsm.sv
hdl/lfjt_checker.sv
verif/tb.sv
